/* rtl/log_event_crc32_checker_core_defines.svh */
// ----------------------------------------------------------------------------
// Log event CRC-32 checker assertion macros
// Shared assertion forms for clocked checks on clk with active-low rst_n.
// ----------------------------------------------------------------------------
`ifndef LOG_EVENT_CRC32_CHECKER_CORE_DEFINES_SVH
`define LOG_EVENT_CRC32_CHECKER_CORE_DEFINES_SVH

// same-cycle implication
`define LECC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LECC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lecc_pkg.sv */
// ----------------------------------------------------------------------------
// Log event CRC-32 checker package
// Shared types, register indexes, constants and the byte-wise CRC update.
// ----------------------------------------------------------------------------
package lecc_pkg;

  localparam int LECC_QDEPTH = 4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHECK_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TYPE_OFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLAGS_OFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FMT_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_USE_MASK  = 3'd4;

  localparam logic       RST_CHECK_EN  = 1'b1;
  localparam logic [7:0] RST_TYPE_OFF  = 8'd4;
  localparam logic [7:0] RST_FLAGS_OFF = 8'd17;
  localparam logic [7:0] RST_FMT_CODE  = 8'd15;
  localparam logic [7:0] RST_USE_MASK  = 8'd1;

  localparam logic [7:0]  POS_MAX       = 8'hFF;
  localparam logic [7:0]  TRAILER_BYTES = 8'd4;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

  typedef struct packed {
    logic       check_en;
    logic [7:0] type_off;
    logic [7:0] flags_off;
    logic [7:0] fmt_code;
    logic [7:0] use_mask;
  } lecc_cfg_t;

  typedef struct packed {
    logic        feed;
    logic [7:0]  crc_byte;
    logic        last;
    logic        too_short;
    logic        check_en;
    logic [31:0] received;
  } lecc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lecc_qstat_t;

  function automatic logic [31:0] lecc_crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/lecc_queue.sv */
// ----------------------------------------------------------------------------
// Log event CRC-32 checker item queue
// Small register FIFO between the classifying front and the CRC back end.
// ----------------------------------------------------------------------------
module lecc_queue
  import lecc_pkg::*;
#(
  parameter int DEPTH = LECC_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  lecc_entry_t wr_entry,
  input  logic        rd_en,
  output lecc_entry_t rd_entry,
  output lecc_qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lecc_entry_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  assign rd_entry    = mem_r[rd_ptr_r];
  assign qstat.full  = (cnt_r == CNT_FULL);
  assign qstat.empty = (cnt_r == '0);

endmodule

/* rtl/lecc_front.sv */
// ----------------------------------------------------------------------------
// Log event CRC-32 checker front end
// Tracks byte position, format-event detection and the trailer delay line;
// turns each input item into one queue entry for the CRC back end.
// ----------------------------------------------------------------------------
module lecc_front
  import lecc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  lecc_cfg_t             cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  input  lecc_qstat_t           qstat,
  output logic                  push,
  output lecc_entry_t           entry
);

  logic [7:0] pos_r, pos_nxt;
  logic       fmt_r, fmt_nxt;
  logic [7:0] dly_r [4];
  logic       type_hit;
  logic       flags_hit;
  logic       fmt_now;
  logic       pos_live;
  logic       short_ev;

  assign in_tready = !qstat.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    pos_live  = (pos_r != POS_MAX);
    type_hit  = pos_live && (pos_r == cfg.type_off);
    fmt_now   = type_hit ? (in_tdata == cfg.fmt_code) : fmt_r;
    flags_hit = pos_live && (pos_r >= TRAILER_BYTES)
                && ((pos_r - TRAILER_BYTES) == cfg.flags_off);
    pos_nxt   = pos_live ? pos_r + 8'd1 : POS_MAX;
    short_ev  = (pos_nxt < TRAILER_BYTES);

    entry.feed      = (pos_r >= TRAILER_BYTES);
    entry.crc_byte  = (flags_hit && fmt_now) ? (dly_r[0] & ~cfg.use_mask) : dly_r[0];
    entry.last      = in_tlast;
    entry.too_short = short_ev;
    entry.check_en  = cfg.check_en;
    entry.received  = short_ev ? 32'd0 : {in_tdata, dly_r[3], dly_r[2], dly_r[1]};

    fmt_nxt = fmt_now;
    if (in_tlast) begin
      pos_nxt = '0;
      fmt_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fmt_r <= 1'b0;
    end else if (push) begin
      pos_r <= pos_nxt;
      fmt_r <= fmt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      dly_r[0] <= dly_r[1];
      dly_r[1] <= dly_r[2];
      dly_r[2] <= dly_r[3];
      dly_r[3] <= in_tdata;
    end
  end

endmodule

/* rtl/lecc_back.sv */
// ----------------------------------------------------------------------------
// Log event CRC-32 checker back end
// Folds queued bytes into the running CRC and registers one result per event.
// ----------------------------------------------------------------------------
module lecc_back
  import lecc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  lecc_qstat_t            qstat,
  input  lecc_entry_t            entry,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [31:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        failed_r;
  logic        short_r;
  logic [31:0] computed_r;
  logic [31:0] received_r;
  logic [31:0] crc_upd;
  logic [31:0] computed;
  logic        slot_free;

  always_comb begin
    slot_free = !out_valid_r || out_tready;
    pop       = !qstat.empty && (!entry.last || slot_free);
    crc_upd   = entry.feed ? lecc_crc_byte(crc_r, entry.crc_byte) : crc_r;
    computed  = entry.too_short ? 32'd0 : ~crc_upd;

    crc_nxt = crc_r;
    if (pop) begin
      crc_nxt = entry.last ? CRC_INIT : crc_upd;
    end

    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && entry.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.last) begin
      failed_r   <= entry.check_en && (entry.too_short || (computed != entry.received));
      short_r    <= entry.too_short;
      computed_r <= computed;
      received_r <= entry.received;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, received_r, computed_r, short_r, failed_r};

endmodule

/* rtl/log_event_crc32_checker_core.sv */
// ----------------------------------------------------------------------------
// Log event CRC-32 checker core
// Result path: the last byte of an event is written to the queue, popped by the back
//   end and captured in the output register, when the output side is not stalled.
// Throughput: 1 byte per cycle via the byte-wise CRC update, barring back-pressure.
// Reset: synchronous active-low rst_n clears the queue, event state and output
//   valid, loads the CRC start value and the register defaults.
// ----------------------------------------------------------------------------
`include "log_event_crc32_checker_core_defines.svh"

module log_event_crc32_checker_core
  import lecc_pkg::*;
#(
  parameter int QUEUE_DEPTH = LECC_QDEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] event_byte
  input  logic                   in_tlast,   // event_last
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [0] check_failed, [1] too_short,
                                             // [33:2] computed_crc,
                                             // [65:34] received_crc, [71:66] zero
);

  lecc_cfg_t   cfg_r;
  lecc_qstat_t qstat;
  lecc_entry_t wr_entry;
  lecc_entry_t rd_entry;
  logic        push;
  logic        pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_en  <= RST_CHECK_EN;
      cfg_r.type_off  <= RST_TYPE_OFF;
      cfg_r.flags_off <= RST_FLAGS_OFF;
      cfg_r.fmt_code  <= RST_FMT_CODE;
      cfg_r.use_mask  <= RST_USE_MASK;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_CHECK_EN:  cfg_r.check_en  <= cfg_wdata[0];
        CFG_IDX_TYPE_OFF:  cfg_r.type_off  <= cfg_wdata;
        CFG_IDX_FLAGS_OFF: cfg_r.flags_off <= cfg_wdata;
        CFG_IDX_FMT_CODE:  cfg_r.fmt_code  <= cfg_wdata;
        CFG_IDX_USE_MASK:  cfg_r.use_mask  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lecc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .qstat     (qstat),
    .push      (push),
    .entry     (wr_entry)
  );

  lecc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_entry (wr_entry),
    .rd_en    (pop),
    .rd_entry (rd_entry),
    .qstat    (qstat)
  );

  lecc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .entry      (rd_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `LECC_ASSERT_IMPL(a_full_blocks_input, qstat.full, !in_tready, "input taken while queue full")
  `LECC_ASSERT_IMPL(a_short_zero_crc, out_tvalid && out_tdata[1], out_tdata[65:2] == 64'd0, "short event with nonzero CRC fields")
  `LECC_ASSERT_NEXT(a_empty_no_new_result, qstat.empty && !out_tvalid, !out_tvalid, "result without a queued item")

endmodule
